### hdl/ordered_dither_rgb333_reduce_unit_assert.svh
// assertion macros for the ordered dither reducer
// each macro takes a label, an antecedent and a consequent
`ifndef ORDERED_DITHER_RGB333_REDUCE_UNIT_ASSERT_SVH
`define ORDERED_DITHER_RGB333_REDUCE_UNIT_ASSERT_SVH

// same-cycle implication
`define ODR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odr333 assertion failed");

// next-cycle implication
`define ODR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odr333 assertion failed");

`endif

### hdl/odr333_pkg.sv
`default_nettype none

package odr333_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 4096;

  // configuration port
  localparam int CFG_IDX_W    = 8;
  localparam int LINE_WIDTH_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 8'd1;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 13'd256;
  // largest line width the 13-bit register can express
  localparam int LINE_WIDTH_CAP = 8191;

  // signed product c*(2k-63) fits in 15 bits
  localparam int PROD_W = 15;
  // floor(x/1008) as (x*DIV_RECIP) >> DIV_SHIFT, exact for x below 17073
  localparam logic [PROD_W-1:0] DIV_RECIP = 15'd16645;
  localparam int DIV_SHIFT = 24;
  localparam logic [PROD_W-1:0] DIV_BIAS = 15'd1007;
  localparam int QUOT_W = 6;

  localparam logic [5:0] BAYER_RANK [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [8:0]  color_index;
    logic [18:0] reduced_color;
  } out_beat_t;

  // threshold matrix position of the pixel being accepted
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } phase_t;

endpackage

`default_nettype wire

### hdl/odr333_phase.sv
`default_nettype none

module odr333_phase #(
  parameter int MAX_LINE_WIDTH = odr333_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                frame_start,
  input  logic [odr333_pkg::LINE_WIDTH_W-1:0] line_width,
  output odr333_pkg::phase_t                  phase
);
  import odr333_pkg::*;

  localparam int WMAX  = (MAX_LINE_WIDTH < LINE_WIDTH_CAP) ? MAX_LINE_WIDTH : LINE_WIDTH_CAP;
  localparam int COL_W = $clog2(WMAX);

  logic [COL_W-1:0]        col_r, col_nxt;
  logic [2:0]              row_r, row_nxt;
  logic [COL_W-1:0]        col_cur;
  logic [2:0]              row_cur;
  logic [LINE_WIDTH_W-1:0] width_eff;
  logic [LINE_WIDTH_W-1:0] col_inc;

  always_comb begin
    col_cur = frame_start ? '0 : col_r;
    row_cur = frame_start ? '0 : row_r;
    // zero width acts as one, oversize widths saturate
    if (line_width == '0) begin
      width_eff = LINE_WIDTH_W'(1);
    end else if (line_width > LINE_WIDTH_W'(WMAX)) begin
      width_eff = LINE_WIDTH_W'(WMAX);
    end else begin
      width_eff = line_width;
    end
    col_inc = LINE_WIDTH_W'(col_cur) + LINE_WIDTH_W'(1);
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      row_nxt = row_cur + 3'd1;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_cur;
    end
  end

  assign phase.row = row_cur;
  assign phase.col = col_cur[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/odr333_chan.sv
`default_nettype none

module odr333_chan (
  input  logic                                 dither_en,
  input  logic [7:0]                           chan_in,
  input  logic signed [odr333_pkg::PROD_W-1:0] prod,
  output logic [7:0]                           chan_out
);
  import odr333_pkg::*;

  logic              neg;
  logic [PROD_W-1:0] mag;
  logic [2*PROD_W-1:0] scaled;
  logic [QUOT_W-1:0] qmag;
  logic [9:0]        q_u;
  logic [9:0]        q_s;
  logic [9:0]        sum;

  always_comb begin
    neg = prod[PROD_W-1];
    // negative side rounds toward minus infinity: -ceil(|p|/1008)
    mag = neg ? (~prod + DIV_BIAS + PROD_W'(1)) : prod;
    scaled = (2*PROD_W)'(mag) * (2*PROD_W)'(DIV_RECIP);
    qmag = scaled[DIV_SHIFT +: QUOT_W];
    q_u = {4'b0000, qmag};
    q_s = neg ? (~q_u + 10'd1) : q_u;
    sum = {2'b00, chan_in} + q_s;
    if (!dither_en) begin
      chan_out = chan_in;
    end else if (sum[9]) begin
      chan_out = 8'd0;
    end else if (sum[8]) begin
      chan_out = 8'd255;
    end else begin
      chan_out = sum[7:0];
    end
  end

endmodule

`default_nettype wire

### hdl/ordered_dither_rgb333_reduce_unit.sv
// ordered dither rgb888 to rgb333 reducer
// path: each input beat passes the product register, then the result register
// throughput: one pixel per cycle; stall on the result side backs up through both stages
// reset: pipeline empty, column and row phase zero, dither on, line width 256
`default_nettype none

module ordered_dither_rgb333_reduce_unit #(
  parameter int MAX_LINE_WIDTH = odr333_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  odr333_pkg::in_beat_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output odr333_pkg::out_beat_t               out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [odr333_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [odr333_pkg::LINE_WIDTH_W-1:0] cfg_data
);
  import odr333_pkg::*;

  logic                    dither_enable_r;
  logic [LINE_WIDTH_W-1:0] line_width_r;

  logic      in_accept;
  logic      s1_adv;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;

  phase_t            phase;
  logic [5:0]        rank;
  logic signed [7:0] offs;
  logic [7:0]        chan_c [3];
  logic signed [PROD_W-1:0] prod_c [3];
  logic signed [16:0]       prod_full [3];
  logic [7:0]               s1_chan_r [3];
  logic signed [PROD_W-1:0] s1_prod_r [3];
  logic [7:0]               chan_d [3];
  logic [8:0]               out_index_chk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dither_enable_r <= 1'b1;
      line_width_r    <= LINE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DITHER_ENABLE: dither_enable_r <= cfg_data[0];
        REG_LINE_WIDTH:    line_width_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1 takes a beat when empty or when it hands its beat on
  assign s1_adv    = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept | (s1_valid_r & ~s1_adv);
  assign out_valid_nxt = s1_adv | (out_valid_r & out_stall);

  odr333_phase #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .frame_start (in_data.frame_start),
    .line_width  (line_width_r),
    .phase       (phase)
  );

  assign chan_c[0] = in_data.red;
  assign chan_c[1] = in_data.green;
  assign chan_c[2] = in_data.blue;

  // c * (2k - 63) per channel, registered before the reciprocal multiply
  always_comb begin
    rank = BAYER_RANK[{phase.row, phase.col}];
    offs = $signed({1'b0, rank, 1'b0}) - 8'sd63;
    for (int i = 0; i < 3; i++) begin
      prod_full[i] = $signed({1'b0, chan_c[i]}) * offs;
      prod_c[i]    = prod_full[i][PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < 3; i++) begin
        s1_chan_r[i] <= chan_c[i];
        s1_prod_r[i] <= prod_c[i];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_chan
    odr333_chan u_chan (
      .dither_en (dither_enable_r),
      .chan_in   (s1_chan_r[g]),
      .prod      (s1_prod_r[g]),
      .chan_out  (chan_d[g])
    );
  end

  always_comb begin
    out_beat_nxt.color_index   = {chan_d[0][7:5], chan_d[1][7:5], chan_d[2][7:5]};
    out_beat_nxt.reduced_color = {chan_d[0][7:5], 5'b00000, chan_d[1][7:5], 5'b00000,
                                  chan_d[2][7:5]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  assign out_index_chk = {out_beat_r.reduced_color[18:16], out_beat_r.reduced_color[10:8],
                          out_beat_r.reduced_color[2:0]};

`include "ordered_dither_rgb333_reduce_unit_assert.svh"

  // a stall at the input only comes from a full pipe held at the output
  `ODR_ASSERT_IMP(a_stall_full, in_stall, s1_valid_r && out_valid_r && out_stall)
  // a beat leaving stage 1 shows up at the output
  `ODR_ASSERT_NXT(a_adv_lands, s1_adv, out_valid_r)
  // index and colour word carry the same bits
  `ODR_ASSERT_IMP(a_pack_match, out_valid_r, out_beat_r.color_index == out_index_chk)

endmodule

`default_nettype wire
